// ----- src/rsi_pkg.sv -----
package rsi_pkg;

  // Default fixed-point format: Q16.16
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Vector components handled side by side (x, y, z)
  localparam int unsigned LANES = 3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_ZERO_DIR = 2'd2,
    ST_HIT_SAT  = 2'd3
  } hit_status_e;

  localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    hit_status_e        hit_status;
    logic               inside_flag;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
  } result_t;

endpackage

// ----- src/rsi_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt #(
  parameter int unsigned RW = 64,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [RW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned NS = RW / 2;

  logic          vld_q  [NS];
  logic [RW-1:0] op_q   [NS];
  logic [RW-1:0] res_q  [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [RW-1:0] ONE = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);

    logic          vld_in;
    logic [RW-1:0] op_in;
    logic [RW-1:0] res_in;
    logic [SW-1:0] side_in;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign op_in   = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign op_in   = op_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + ONE;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    // keep the remainder when the trial bit fits, else drop the bit
    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      if (op_in >= trial) begin
        op_q[k]  <= op_in - trial;
        res_q[k] <= (res_in >> 1) + ONE;
      end else begin
        op_q[k]  <= op_in;
        res_q[k] <= res_in >> 1;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = res_q[NS-1][NS-1:0];
  assign side_o  = side_q[NS-1];

endmodule

// ----- src/rsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
module rsi_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [rsi_pkg::LANES-1:0][NW-1:0]    num_i,
  input  logic [DW-1:0]                        den_i,
  input  logic [SW-1:0]                        side_i,
  output logic                                 valid_o,
  output logic [rsi_pkg::LANES-1:0][QW-1:0]    quo_o,
  output logic [SW-1:0]                        side_o
);

  localparam int unsigned L  = rsi_pkg::LANES;
  localparam int unsigned CW = DW + QW;

  logic                   vld_q  [QW];
  logic [L-1:0][CW-1:0]   rem_q  [QW];
  logic [L-1:0][QW-1:0]   quo_q  [QW];
  logic [DW-1:0]          den_q  [QW];
  logic [SW-1:0]          side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                 vld_in;
    logic [L-1:0][CW-1:0] rem_in;
    logic [L-1:0][QW-1:0] quo_in;
    logic [DW-1:0]        den_in;
    logic [SW-1:0]        side_in;
    logic [CW-1:0]        dsh;

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < L; i++) begin
          rem_in[i] = CW'(num_i[i]);
        end
      end
      assign vld_in  = valid_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = CW'(den_in) << (QW - 1 - k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
      for (int i = 0; i < L; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_q[k][i] <= rem_in[i] - dsh;
          quo_q[k][i] <= {quo_in[i][QW-2:0], 1'b1};
        end else begin
          rem_q[k][i] <= rem_in[i];
          quo_q[k][i] <= {quo_in[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ----- src/ray_sphere_intersection.sv -----
// Pipeline: seven front stages, a 32-stage length root, a FRAC_BITS + 1 stage divider
//   (FRAC_BITS is 16 at Q16.16), five stages up to the squared half-chord, a 34-stage
//   half-chord root and three stages to the output register.
// Throughput: one ray per clock cycle; busy_o never rises, every transaction is taken.
// Results are strobed for one cycle; the receiver cannot stall the pipeline.
// Reset (rst_ni low, asynchronous) empties the pipeline and returns the sphere
//   to centre 0 and radius 1.0.
module ray_sphere_intersection #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  rsi_pkg::ray_t                    ray_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             result_valid_o,
  output rsi_pkg::result_t                 result_o
);

  localparam int unsigned L     = rsi_pkg::LANES;
  localparam int unsigned UW    = FRAC_BITS + 2;   // signed unit direction component
  localparam int unsigned QW    = FRAC_BITS + 1;   // its magnitude
  localparam int unsigned NW    = 32 + FRAC_BITS;  // divider numerator
  localparam int unsigned OCW   = 33;              // centre minus origin
  localparam int unsigned OCSQW = 65;              // one square of it
  localparam int unsigned OCCW  = 67;              // |oc|^2
  localparam int unsigned RRW   = 62;              // r^2
  localparam int unsigned DIFW  = 68;              // r^2 - |oc|^2, and thc^2
  localparam int unsigned SHW   = 5;               // direction normalising shift
  localparam int unsigned LENW  = 32;              // direction length
  localparam int unsigned DDW   = 64;              // squared direction length
  localparam int unsigned TCW   = 34;              // tca
  localparam int unsigned THW   = DIFW / 2;        // thc
  localparam int unsigned TW    = 36;              // ray parameter t
  localparam int unsigned MW    = UW + OCW;        // u * oc
  localparam int unsigned ACW   = MW + 2;
  localparam int unsigned PW    = UW + TW;         // u * t
  localparam int unsigned HSW   = PW - FRAC_BITS;
  localparam int unsigned HW    = HSW + 1;         // origin plus offset

  // ---------------------------------------------------------------------------
  // Stage payload types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [L-1:0][31:0]    o;
    logic [L-1:0][OCW-1:0] oc;
    logic [L-1:0][31:0]    s;
    logic [L-1:0]          neg;
  } st2_t;

  typedef struct packed {
    st2_t                    a;
    logic [L-1:0][OCSQW-1:0] sq;
    logic [RRW-1:0]          rr;
    logic [31:0]             mx;
  } st3_t;

  typedef struct packed {
    st2_t            a;
    logic            in_sph;
    logic            zero;
    logic [DIFW-1:0] diff;
    logic [SHW-1:0]  sh;
  } st4_t;

  typedef struct packed {
    logic [L-1:0][31:0]    o;
    logic [L-1:0][OCW-1:0] oc;
    logic [L-1:0]          neg;
    logic [L-1:0][31:0]    ns;
    logic                  in_sph;
    logic                  zero;
    logic [DIFW-1:0]       diff;
  } sd1_t;

  typedef struct packed {
    sd1_t               a;
    logic [L-1:0][63:0] nsq;
  } st6_t;

  typedef struct packed {
    sd1_t           a;
    logic [DDW-1:0] dd;
  } st7_t;

  typedef struct packed {
    logic [L-1:0][31:0]    o;
    logic [L-1:0][OCW-1:0] oc;
    logic [L-1:0]          neg;
    logic                  in_sph;
    logic                  zero;
    logic [DIFW-1:0]       diff;
  } sd2_t;

  typedef struct packed {
    logic [L-1:0][31:0]    o;
    logic [L-1:0][OCW-1:0] oc;
    logic [L-1:0][UW-1:0]  u;
    logic                  in_sph;
    logic                  zero;
    logic [DIFW-1:0]       diff;
  } st8_t;

  typedef struct packed {
    logic [L-1:0][31:0]   o;
    logic [L-1:0][UW-1:0] u;
    logic                 in_sph;
    logic                 zero;
    logic [DIFW-1:0]      diff;
    logic [L-1:0][MW-1:0] m;
  } st9_t;

  typedef struct packed {
    logic [L-1:0][31:0]   o;
    logic [L-1:0][UW-1:0] u;
    logic                 in_sph;
    logic                 zero;
    logic [DIFW-1:0]      diff;
    logic [TCW-1:0]       tca;
  } st10_t;

  typedef struct packed {
    logic [L-1:0][31:0]   o;
    logic [L-1:0][UW-1:0] u;
    logic                 in_sph;
    logic                 zero;
    logic [DIFW-1:0]      diff;
    logic [TCW-1:0]       tca;
    logic [DIFW-1:0]      tsq;
    logic                 miss;
  } st11_t;

  typedef struct packed {
    logic [L-1:0][31:0]   o;
    logic [L-1:0][UW-1:0] u;
    logic [TCW-1:0]       tca;
    logic                 in_sph;
    logic                 zero;
    logic                 miss;
  } sd3_t;

  typedef struct packed {
    sd3_t            a;
    logic [DIFW-1:0] rad;
  } st12_t;

  typedef struct packed {
    logic [L-1:0][31:0]   o;
    logic [L-1:0][UW-1:0] u;
    logic                 in_sph;
    logic                 zero;
    logic                 miss;
    logic [TW-1:0]        t;
  } st13_t;

  typedef struct packed {
    logic [L-1:0][31:0]   o;
    logic                 in_sph;
    logic                 zero;
    logic                 miss;
    logic [L-1:0][PW-1:0] p;
  } st14_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; user must write only with the pipeline empty, not enforced.
  // ---------------------------------------------------------------------------
  logic [L-1:0][31:0] center_q;
  logic [30:0]        radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= {{30{1'b0}}, 1'b1} << FRAC_BITS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rsi_pkg::cfg_idx_e'(cfg_index_i))
        rsi_pkg::CFG_CENTER_X: center_q[0] <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Y: center_q[1] <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Z: center_q[2] <= cfg_data_i;
        rsi_pkg::CFG_RADIUS:   radius_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Every cycle is open to a new transaction; nothing in the pipeline stalls.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid bits. va_q[k] travels with stage k (1-7). vb_q[8..11] travel with
  // stages 8-11; vb_q[12], vb_q[13] and vb_q[14] travel with the stage 13,
  // stage 14 and output registers behind the half-chord root.
  // ---------------------------------------------------------------------------
  logic [7:1]  va_q;
  logic [14:8] vb_q;
  logic        len_vld;
  logic        quo_vld;
  logic        thc_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= '0;
      vb_q        <= '0;
    end else begin
      va_q        <= {va_q[6:1], start_i && !busy_o};
      vb_q[8]     <= quo_vld;
      vb_q[9]     <= vb_q[8];
      vb_q[10]    <= vb_q[9];
      vb_q[11]    <= vb_q[10];
      vb_q[12]    <= thc_vld;
      vb_q[13]    <= vb_q[12];
      vb_q[14]    <= vb_q[13];
    end
  end

  // (stages 8..11 -> thc^2 register -> root -> 13, 14 -> output register)

  // ---------------------------------------------------------------------------
  // Stage 1: capture the ray
  // ---------------------------------------------------------------------------
  rsi_pkg::ray_t ray1_q;

  always_ff @(posedge clk_i) begin
    ray1_q <= ray_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: oc = centre - origin, direction magnitudes
  // ---------------------------------------------------------------------------
  st2_t st2_d, st2_q;

  always_comb begin
    logic [L-1:0][31:0] org;
    logic [L-1:0][31:0] dir;
    org = {ray1_q.origin_z, ray1_q.origin_y, ray1_q.origin_x};
    dir = {ray1_q.dir_z, ray1_q.dir_y, ray1_q.dir_x};
    for (int i = 0; i < L; i++) begin
      st2_d.o[i]   = org[i];
      st2_d.oc[i]  = {center_q[i][31], center_q[i]} - {org[i][31], org[i]};
      st2_d.neg[i] = dir[i][31];
      st2_d.s[i]   = dir[i][31] ? (~dir[i] + 32'd1) : dir[i];
    end
  end

  always_ff @(posedge clk_i) begin
    st2_q <= st2_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squares of oc, r^2, largest direction magnitude
  // ---------------------------------------------------------------------------
  st3_t st3_d, st3_q;

  always_comb begin
    logic signed [2*OCW-1:0] sq_full;
    st3_d.a = st2_q;
    for (int i = 0; i < L; i++) begin
      sq_full       = $signed(st2_q.oc[i]) * $signed(st2_q.oc[i]);
      st3_d.sq[i]   = sq_full[OCSQW-1:0];
    end
    st3_d.rr = radius_q * radius_q;
    st3_d.mx = st2_q.s[0];
    for (int i = 1; i < L; i++) begin
      if (st2_q.s[i] > st3_d.mx) begin
        st3_d.mx = st2_q.s[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st3_q <= st3_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: |oc|^2, inside test, r^2 - |oc|^2, normalising shift
  // ---------------------------------------------------------------------------
  st4_t st4_d, st4_q;

  always_comb begin
    logic [OCCW-1:0] occ;
    occ = '0;
    for (int i = 0; i < L; i++) begin
      occ = occ + {2'b00, st3_q.sq[i]};
    end
    st4_d.a      = st3_q.a;
    // origin on the surface counts as outside
    st4_d.in_sph = occ < {5'b0, st3_q.rr};
    st4_d.diff   = {6'b0, st3_q.rr} - {1'b0, occ};
    st4_d.zero   = (st3_q.mx == '0);
    // bring the largest magnitude up to bit 30
    st4_d.sh     = '0;
    for (int b = 0; b < 31; b++) begin
      if (st3_q.mx[b]) begin
        st4_d.sh = SHW'(30 - b);
      end
    end
    if (st3_q.mx[31]) begin
      st4_d.sh = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q <= st4_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: normalised magnitudes
  // ---------------------------------------------------------------------------
  sd1_t st5_d, st5_q;

  always_comb begin
    st5_d.o      = st4_q.a.o;
    st5_d.oc     = st4_q.a.oc;
    st5_d.neg    = st4_q.a.neg;
    st5_d.in_sph = st4_q.in_sph;
    st5_d.zero   = st4_q.zero;
    st5_d.diff   = st4_q.diff;
    for (int i = 0; i < L; i++) begin
      st5_d.ns[i] = st4_q.a.s[i] << st4_q.sh;
    end
  end

  always_ff @(posedge clk_i) begin
    st5_q <= st5_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 6: squares of the normalised magnitudes
  // ---------------------------------------------------------------------------
  st6_t st6_d, st6_q;

  always_comb begin
    st6_d.a = st5_q;
    for (int i = 0; i < L; i++) begin
      st6_d.nsq[i] = st5_q.ns[i] * st5_q.ns[i];
    end
  end

  always_ff @(posedge clk_i) begin
    st6_q <= st6_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: squared length (fits 64 bits after normalising)
  // ---------------------------------------------------------------------------
  st7_t st7_d, st7_q;

  always_comb begin
    st7_d.a  = st6_q.a;
    st7_d.dd = '0;
    for (int i = 0; i < L; i++) begin
      st7_d.dd = st7_d.dd + st6_q.nsq[i];
    end
  end

  always_ff @(posedge clk_i) begin
    st7_q <= st7_d;
  end

  // ---------------------------------------------------------------------------
  // Direction length: floor(sqrt(dd)), 32 stages
  // ---------------------------------------------------------------------------
  logic [LENW-1:0] len;
  sd1_t            sd1_out;

  rsi_sqrt #(
    .RW (DDW),
    .SW ($bits(sd1_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q[7]),
    .rad_i   (st7_q.dd),
    .side_i  (st7_q.a),
    .valid_o (len_vld),
    .root_o  (len),
    .side_o  (sd1_out)
  );

  // ---------------------------------------------------------------------------
  // Unit direction magnitudes: (ns << FRAC_BITS) / len, FRAC_BITS + 1 stages
  // ---------------------------------------------------------------------------
  logic [L-1:0][NW-1:0] div_num;
  sd2_t                 sd2_in;
  sd2_t                 sd2_out;
  logic [L-1:0][QW-1:0] quo;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      div_num[i] = {sd1_out.ns[i], {FRAC_BITS{1'b0}}};
    end
    sd2_in.o      = sd1_out.o;
    sd2_in.oc     = sd1_out.oc;
    sd2_in.neg    = sd1_out.neg;
    sd2_in.in_sph = sd1_out.in_sph;
    sd2_in.zero   = sd1_out.zero;
    sd2_in.diff   = sd1_out.diff;
  end

  rsi_div #(
    .NW (NW),
    .DW (LENW),
    .QW (QW),
    .SW ($bits(sd2_t))
  ) u_dir_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (len_vld),
    .num_i   (div_num),
    .den_i   (len),
    .side_i  (sd2_in),
    .valid_o (quo_vld),
    .quo_o   (quo),
    .side_o  (sd2_out)
  );

  // ---------------------------------------------------------------------------
  // Stage 8: restore the direction signs
  // ---------------------------------------------------------------------------
  st8_t st8_d, st8_q;

  always_comb begin
    logic [UW-1:0] qe;
    st8_d.o      = sd2_out.o;
    st8_d.oc     = sd2_out.oc;
    st8_d.in_sph = sd2_out.in_sph;
    st8_d.zero   = sd2_out.zero;
    st8_d.diff   = sd2_out.diff;
    for (int i = 0; i < L; i++) begin
      qe          = {1'b0, quo[i]};
      st8_d.u[i]  = sd2_out.neg[i] ? (~qe + UW'(1)) : qe;
    end
  end

  always_ff @(posedge clk_i) begin
    st8_q <= st8_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 9: u_i * oc_i
  // ---------------------------------------------------------------------------
  st9_t st9_d, st9_q;

  always_comb begin
    logic signed [MW-1:0] prod;
    st9_d.o      = st8_q.o;
    st9_d.u      = st8_q.u;
    st9_d.in_sph = st8_q.in_sph;
    st9_d.zero   = st8_q.zero;
    st9_d.diff   = st8_q.diff;
    for (int i = 0; i < L; i++) begin
      prod        = $signed(st8_q.u[i]) * $signed(st8_q.oc[i]);
      st9_d.m[i]  = prod;
    end
  end

  always_ff @(posedge clk_i) begin
    st9_q <= st9_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 10: tca = floor(sum / 2^FRAC_BITS)
  // ---------------------------------------------------------------------------
  st10_t st10_d, st10_q;

  always_comb begin
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] acc_sh;
    acc = '0;
    for (int i = 0; i < L; i++) begin
      acc = acc + ACW'($signed(st9_q.m[i]));
    end
    acc_sh        = acc >>> FRAC_BITS;
    st10_d.o      = st9_q.o;
    st10_d.u      = st9_q.u;
    st10_d.in_sph = st9_q.in_sph;
    st10_d.zero   = st9_q.zero;
    st10_d.diff   = st9_q.diff;
    st10_d.tca    = acc_sh[TCW-1:0];
  end

  always_ff @(posedge clk_i) begin
    st10_q <= st10_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 11: tca^2; a ray pointing away from outside misses
  // ---------------------------------------------------------------------------
  st11_t st11_d, st11_q;

  always_comb begin
    logic signed [DIFW-1:0] tsq;
    tsq           = $signed(st10_q.tca) * $signed(st10_q.tca);
    st11_d.o      = st10_q.o;
    st11_d.u      = st10_q.u;
    st11_d.in_sph = st10_q.in_sph;
    st11_d.zero   = st10_q.zero;
    st11_d.diff   = st10_q.diff;
    st11_d.tca    = st10_q.tca;
    st11_d.tsq    = tsq;
    st11_d.miss   = st10_q.tca[TCW-1] && !st10_q.in_sph;
  end

  always_ff @(posedge clk_i) begin
    st11_q <= st11_d;
  end

  // ---------------------------------------------------------------------------
  // Squared half-chord; negative means the ray misses
  // ---------------------------------------------------------------------------
  st12_t st12_d, st12_q;
  logic  th2_vld_q;

  always_comb begin
    logic [DIFW-1:0] th2;
    th2             = st11_q.diff + st11_q.tsq;
    st12_d.a.o      = st11_q.o;
    st12_d.a.u      = st11_q.u;
    st12_d.a.tca    = st11_q.tca;
    st12_d.a.in_sph = st11_q.in_sph;
    st12_d.a.zero   = st11_q.zero;
    st12_d.a.miss   = st11_q.miss || th2[DIFW-1];
    st12_d.rad      = th2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th2_vld_q <= 1'b0;
    end else begin
      th2_vld_q <= vb_q[11];
    end
  end

  always_ff @(posedge clk_i) begin
    st12_q <= st12_d;
  end

  // ---------------------------------------------------------------------------
  // Half-chord: floor(sqrt(thc^2)), DIFW/2 stages
  // ---------------------------------------------------------------------------
  logic [THW-1:0] thc;
  sd3_t           sd3_out;

  rsi_sqrt #(
    .RW (DIFW),
    .SW ($bits(sd3_t))
  ) u_thc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (th2_vld_q),
    .rad_i   (st12_q.rad),
    .side_i  (st12_q.a),
    .valid_o (thc_vld),
    .root_o  (thc),
    .side_o  (sd3_out)
  );

  // ---------------------------------------------------------------------------
  // Stage 13: near hit from outside, far hit from inside
  // ---------------------------------------------------------------------------
  st13_t st13_d, st13_q;

  always_comb begin
    logic [TW-1:0] tca_x;
    logic [TW-1:0] thc_x;
    tca_x         = {{(TW-TCW){sd3_out.tca[TCW-1]}}, sd3_out.tca};
    thc_x         = {{(TW-THW){1'b0}}, thc};
    st13_d.o      = sd3_out.o;
    st13_d.u      = sd3_out.u;
    st13_d.in_sph = sd3_out.in_sph;
    st13_d.zero   = sd3_out.zero;
    st13_d.miss   = sd3_out.miss;
    st13_d.t      = sd3_out.in_sph ? (tca_x + thc_x) : (tca_x - thc_x);
  end

  always_ff @(posedge clk_i) begin
    st13_q <= st13_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 14: u_i * t
  // ---------------------------------------------------------------------------
  st14_t st14_d, st14_q;

  always_comb begin
    logic signed [PW-1:0] prod;
    st14_d.o      = st13_q.o;
    st14_d.in_sph = st13_q.in_sph;
    st14_d.zero   = st13_q.zero;
    st14_d.miss   = st13_q.miss;
    for (int i = 0; i < L; i++) begin
      prod         = $signed(st13_q.u[i]) * $signed(st13_q.t);
      st14_d.p[i]  = prod;
    end
  end

  always_ff @(posedge clk_i) begin
    st14_q <= st14_d;
  end

  // ---------------------------------------------------------------------------
  // Output stage: add the origin, saturate, pick the status
  // ---------------------------------------------------------------------------
  rsi_pkg::result_t result_d, result_q;

  always_comb begin
    logic signed [PW-1:0] p_sh;
    logic [HW-1:0]        h;
    logic [L-1:0][31:0]   coord;
    logic [L-1:0]         sat;
    for (int i = 0; i < L; i++) begin
      p_sh     = $signed(st14_q.p[i]) >>> FRAC_BITS;
      h        = {p_sh[HSW-1], p_sh[HSW-1:0]} +
                 {{(HW-32){st14_q.o[i][31]}}, st14_q.o[i]};
      sat[i]   = !((&h[HW-1:31]) || !(|h[HW-1:31]));
      if (sat[i]) begin
        coord[i] = h[HW-1] ? rsi_pkg::COORD_MIN : rsi_pkg::COORD_MAX;
      end else begin
        coord[i] = h[31:0];
      end
    end

    result_d.inside_flag = st14_q.in_sph;
    result_d.hit_x       = '0;
    result_d.hit_y       = '0;
    result_d.hit_z       = '0;
    if (st14_q.zero) begin
      result_d.hit_status = rsi_pkg::ST_ZERO_DIR;
    end else if (st14_q.miss) begin
      result_d.hit_status = rsi_pkg::ST_MISS;
    end else begin
      result_d.hit_status = (|sat) ? rsi_pkg::ST_HIT_SAT : rsi_pkg::ST_HIT;
      result_d.hit_x      = coord[0];
      result_d.hit_y      = coord[1];
      result_d.hit_z      = coord[2];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  // vb_q[14] travels with the output register
  assign result_valid_o = vb_q[14];
  assign result_o       = result_q;

endmodule

// ----- src/rsi_checker.sv -----
module rsi_checker #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           result_valid_o,
  input rsi_pkg::result_t               result_o
);

  // edges from the accepting edge to the edge that takes the result
  localparam int unsigned LAT = FRAC_BITS + 82;

  // every result traces back to an accepted transaction
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching transaction");

  a_no_hit_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.hit_status == rsi_pkg::ST_MISS ||
                        result_o.hit_status == rsi_pkg::ST_ZERO_DIR))
    |-> (result_o.hit_x == '0 && result_o.hit_y == '0 && result_o.hit_z == '0))
    else $error("non-hit result carries coordinates");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.hit_status == rsi_pkg::ST_HIT_SAT)
    |-> (result_o.hit_x == rsi_pkg::COORD_MAX || result_o.hit_x == rsi_pkg::COORD_MIN ||
         result_o.hit_y == rsi_pkg::COORD_MAX || result_o.hit_y == rsi_pkg::COORD_MIN ||
         result_o.hit_z == rsi_pkg::COORD_MAX || result_o.hit_z == rsi_pkg::COORD_MIN))
    else $error("saturated status without a clamped coordinate");

endmodule

bind ray_sphere_intersection rsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rsi_checker (.*);
